// ----- design/dfia_pkg.sv -----
// Shared constants, codes and types of the deferred-reclaim index allocator.
package dfia_pkg;

  localparam int HEAP_DEPTH  = 4096;
  localparam int DEFER_SLOTS = 3;

  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CAP_W      = 13;
  localparam int SLOT_W     = $clog2(DEFER_SLOTS);
  localparam int PEND_DEPTH = DEFER_SLOTS * HEAP_DEPTH;
  localparam int PEND_AW    = $clog2(PEND_DEPTH);

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RETIRE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_DROPPED   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_RETIRE
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] free_index;
    logic             no_index;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [1:0]       status;
    logic             report_exhaustion;
    logic [CNT_W-1:0] released_count;
  } res_t;

  // Requests from the sequencer to the free stack
  typedef struct packed {
    logic             load;
    logic [CAP_W-1:0] load_cap;
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_data;
  } stk_req_t;

  // Free stack status back to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             push_ok;
    logic [IDX_W-1:0] pop_data;
  } stk_sts_t;

endpackage

// ----- design/dfia_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dfia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/dfia_free_stack.sv -----
// LIFO free stack: RAM, fill count and a low-water mark that stands in for the reload.
module dfia_free_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfia_pkg::stk_req_t  req_i,
  output dfia_pkg::stk_sts_t  sts_o
);

  logic [dfia_pkg::CNT_W-1:0] cap_q, cap_d;
  logic [dfia_pkg::CNT_W-1:0] count_q, count_d;
  logic [dfia_pkg::CNT_W-1:0] lw_q, lw_d;
  logic                       loaded_q, loaded_d;
  logic [dfia_pkg::IDX_W-1:0] loaded_val_q, loaded_val_d;

  logic [dfia_pkg::CNT_W-1:0] cnt_m1;
  logic [dfia_pkg::CNT_W-1:0] pos_w;
  logic [dfia_pkg::CNT_W-1:0] init_val;
  logic [dfia_pkg::IDX_W-1:0] pop_pos;
  logic                       push_ok;
  logic                       ram_we;
  logic [dfia_pkg::IDX_W-1:0] ram_rdata;

  // Entries below the low-water mark were never touched since the last load,
  // so they still hold their loaded value cap-1-pos; the rest come from RAM.
  assign cnt_m1   = count_q - dfia_pkg::CNT_W'(1);
  assign pop_pos  = cnt_m1[dfia_pkg::IDX_W-1:0];
  assign pos_w    = dfia_pkg::CNT_W'(pop_pos);
  assign init_val = cap_q - dfia_pkg::CNT_W'(1) - pos_w;
  assign push_ok  = (count_q < dfia_pkg::CNT_W'(dfia_pkg::HEAP_DEPTH));
  assign ram_we   = req_i.push && push_ok && !req_i.load;

  // Update count, capacity and low-water mark
  always_comb begin
    cap_d        = cap_q;
    count_d      = count_q;
    lw_d         = lw_q;
    loaded_d     = loaded_q;
    loaded_val_d = loaded_val_q;
    if (req_i.load) begin
      if (req_i.load_cap > dfia_pkg::CAP_W'(dfia_pkg::HEAP_DEPTH)) begin
        cap_d = dfia_pkg::CNT_W'(dfia_pkg::HEAP_DEPTH);
      end else begin
        cap_d = dfia_pkg::CNT_W'(req_i.load_cap);
      end
      count_d = cap_d;
      lw_d    = cap_d;
    end else if (req_i.pop) begin
      count_d      = cnt_m1;
      loaded_d     = (pos_w < lw_q);
      loaded_val_d = init_val[dfia_pkg::IDX_W-1:0];
      if (pos_w < lw_q) begin
        lw_d = pos_w;
      end
    end else if (ram_we) begin
      count_d = count_q + dfia_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= dfia_pkg::CNT_W'(dfia_pkg::HEAP_DEPTH);
      count_q      <= dfia_pkg::CNT_W'(dfia_pkg::HEAP_DEPTH);
      lw_q         <= dfia_pkg::CNT_W'(dfia_pkg::HEAP_DEPTH);
      loaded_q     <= 1'b0;
      loaded_val_q <= '0;
    end else begin
      cap_q        <= cap_d;
      count_q      <= count_d;
      lw_q         <= lw_d;
      loaded_q     <= loaded_d;
      loaded_val_q <= loaded_val_d;
    end
  end

  dfia_ram #(
    .WIDTH (dfia_pkg::IDX_W),
    .DEPTH (dfia_pkg::HEAP_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[dfia_pkg::IDX_W-1:0]),
    .wdata_i (req_i.push_data),
    .re_i    (req_i.pop && !req_i.load),
    .raddr_i (pop_pos),
    .rdata_o (ram_rdata)
  );

  assign sts_o.count    = count_q;
  assign sts_o.push_ok  = push_ok;
  assign sts_o.pop_data = loaded_q ? loaded_val_q : ram_rdata;

endmodule

// ----- design/deferred_free_index_allocator.sv -----
// Top level: command sequencer, pending-list RAM and the free stack.
//
//  channel   ports                          direction  beat
//  command   start_i, busy_o, cmd_i         in         start_i && !busy_o
//  result    res_valid_o, res_o             out        res_valid_o (one cycle, no stall)
//  config    cfg_we_i, cfg_data_i           in         cfg_we_i
//
// Free, no-op and an allocate on an empty stack finish from the idle state; any
// other allocate passes through S_ALLOC (one read of the free stack RAM).
// Retire walks its n pending indices in S_RETIRE: the pending RAM is read one
// entry a cycle and each entry is pushed onto the free stack as it arrives.
// The result is registered at the end of the work; a new command may start as it strobes.
// Reset loads the free stack at once (no clearing pass); results cannot be stalled.
module deferred_free_index_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  dfia_pkg::cmd_t               cmd_i,
  output logic                         res_valid_o,
  output dfia_pkg::res_t               res_o,
  input  logic                         cfg_we_i,
  input  logic [dfia_pkg::CAP_W-1:0]   cfg_data_i
);

  dfia_pkg::state_e state_q, state_d;

  logic [dfia_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [dfia_pkg::CNT_W-1:0]  pcnt_q [dfia_pkg::DEFER_SLOTS];
  logic [dfia_pkg::CNT_W-1:0]  pcnt_d [dfia_pkg::DEFER_SLOTS];
  logic [dfia_pkg::CNT_W-1:0]  walk_idx_q, walk_idx_d;
  logic [dfia_pkg::CNT_W-1:0]  walk_len_q, walk_len_d;
  logic                        rd_v_q, rd_v_d;
  logic [dfia_pkg::CNT_W-1:0]  released_q, released_d;
  logic                        drop_q, drop_d;
  logic                        exh_q, exh_d;
  logic                        res_v_q, res_v_d;
  dfia_pkg::res_t              res_q, res_d;

  logic                        accept;
  logic [dfia_pkg::SLOT_W-1:0] next_slot;
  logic [dfia_pkg::SLOT_W-1:0] pc_sel;
  logic [dfia_pkg::CNT_W-1:0]  pc_cur;
  logic                        walk_done;

  logic                        pend_we;
  logic                        pend_re;
  logic [dfia_pkg::PEND_AW-1:0] pend_waddr;
  logic [dfia_pkg::PEND_AW-1:0] pend_raddr;
  logic [dfia_pkg::IDX_W-1:0]  pend_rdata;

  dfia_pkg::stk_req_t          stk_req;
  dfia_pkg::stk_sts_t          stk_sts;

  assign accept    = start_i && (state_q == dfia_pkg::S_IDLE);
  assign busy_o    = (state_q != dfia_pkg::S_IDLE);
  assign next_slot = (slot_q == dfia_pkg::SLOT_W'(dfia_pkg::DEFER_SLOTS - 1)) ?
                     '0 : slot_q + dfia_pkg::SLOT_W'(1);
  assign pc_sel    = (cmd_i.command == dfia_pkg::CMD_RETIRE) ? next_slot : slot_q;
  assign pc_cur    = pcnt_q[pc_sel];
  assign walk_done = (walk_idx_q == walk_len_q);

  // Pending RAM addresses: one list of HEAP_DEPTH entries per frame slot
  assign pend_waddr = dfia_pkg::PEND_AW'(slot_q) * dfia_pkg::PEND_AW'(dfia_pkg::HEAP_DEPTH)
                    + dfia_pkg::PEND_AW'(pc_cur[dfia_pkg::IDX_W-1:0]);
  assign pend_raddr = dfia_pkg::PEND_AW'(slot_q) * dfia_pkg::PEND_AW'(dfia_pkg::HEAP_DEPTH)
                    + dfia_pkg::PEND_AW'(walk_idx_q[dfia_pkg::IDX_W-1:0]);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfia_pkg::S_IDLE: begin
        if (start_i) begin
          if (cmd_i.command == dfia_pkg::CMD_ALLOC && stk_sts.count != '0) begin
            state_d = dfia_pkg::S_ALLOC;
          end else if (cmd_i.command == dfia_pkg::CMD_RETIRE) begin
            state_d = dfia_pkg::S_RETIRE;
          end
        end
      end
      dfia_pkg::S_ALLOC: begin
        state_d = dfia_pkg::S_IDLE;
      end
      dfia_pkg::S_RETIRE: begin
        if (walk_done) begin
          state_d = dfia_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dfia_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath control and result assembly
  always_comb begin
    logic [dfia_pkg::CNT_W-1:0] rel_n;
    logic                       drop_n;
    rel_n             = released_q;
    drop_n            = drop_q;
    slot_d            = slot_q;
    pcnt_d            = pcnt_q;
    walk_idx_d        = walk_idx_q;
    walk_len_d        = walk_len_q;
    rd_v_d            = 1'b0;
    released_d        = released_q;
    drop_d            = drop_q;
    exh_d             = exh_q;
    res_v_d           = 1'b0;
    res_d             = '0;
    pend_we           = 1'b0;
    pend_re           = 1'b0;
    stk_req           = '0;
    stk_req.load      = cfg_we_i;
    stk_req.load_cap  = cfg_data_i;
    stk_req.push_data = pend_rdata;
    unique case (state_q)
      dfia_pkg::S_IDLE: begin
        if (start_i) begin
          case (cmd_i.command)
            dfia_pkg::CMD_ALLOC: begin
              if (stk_sts.count == '0) begin
                res_v_d                 = 1'b1;
                res_d.status            = dfia_pkg::ST_EXHAUSTED;
                res_d.report_exhaustion = !exh_q;
                exh_d                   = 1'b1;
              end else begin
                stk_req.pop = 1'b1;
              end
            end
            dfia_pkg::CMD_FREE: begin
              res_v_d = 1'b1;
              if (!cmd_i.no_index) begin
                if (pc_cur >= dfia_pkg::CNT_W'(dfia_pkg::HEAP_DEPTH)) begin
                  res_d.status = dfia_pkg::ST_DROPPED;
                end else begin
                  pend_we        = 1'b1;
                  pcnt_d[slot_q] = pc_cur + dfia_pkg::CNT_W'(1);
                end
              end
            end
            dfia_pkg::CMD_RETIRE: begin
              slot_d            = next_slot;
              walk_len_d        = pc_cur;
              pcnt_d[next_slot] = '0;
              walk_idx_d        = '0;
              released_d        = '0;
              drop_d            = 1'b0;
            end
            default: begin
              res_v_d = 1'b1;
            end
          endcase
        end
      end
      dfia_pkg::S_ALLOC: begin
        res_v_d     = 1'b1;
        res_d.index = stk_sts.pop_data;
      end
      dfia_pkg::S_RETIRE: begin
        // push the entry read last cycle
        if (rd_v_q) begin
          stk_req.push = 1'b1;
          if (stk_sts.push_ok) begin
            rel_n = released_q + dfia_pkg::CNT_W'(1);
          end else begin
            drop_n = 1'b1;
          end
        end
        released_d = rel_n;
        drop_d     = drop_n;
        // fetch the next entry, or finish
        if (!walk_done) begin
          pend_re    = 1'b1;
          rd_v_d     = 1'b1;
          walk_idx_d = walk_idx_q + dfia_pkg::CNT_W'(1);
        end else begin
          res_v_d              = 1'b1;
          res_d.released_count = rel_n;
          res_d.status         = drop_n ? dfia_pkg::ST_DROPPED : dfia_pkg::ST_OK;
        end
      end
      default: begin
        res_v_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dfia_pkg::S_IDLE;
      slot_q     <= '0;
      pcnt_q     <= '{default: '0};
      walk_idx_q <= '0;
      walk_len_q <= '0;
      rd_v_q     <= 1'b0;
      released_q <= '0;
      drop_q     <= 1'b0;
      exh_q      <= 1'b0;
      res_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      pcnt_q     <= pcnt_d;
      walk_idx_q <= walk_idx_d;
      walk_len_q <= walk_len_d;
      rd_v_q     <= rd_v_d;
      released_q <= released_d;
      drop_q     <= drop_d;
      exh_q      <= exh_d;
      res_v_q    <= res_v_d;
    end
  end

  // Hold the result for its one-cycle beat
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  dfia_ram #(
    .WIDTH (dfia_pkg::IDX_W),
    .DEPTH (dfia_pkg::PEND_DEPTH)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we && accept),
    .waddr_i (pend_waddr),
    .wdata_i (cmd_i.free_index),
    .re_i    (pend_re),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  dfia_free_stack u_free_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stk_req),
    .sts_o  (stk_sts)
  );

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

// ----- design/dfia_checker.sv -----
// Port-level checks of the allocator, bound to the top level.
module dfia_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_o,
  input  dfia_pkg::cmd_t               cmd_i,
  input  logic                         res_valid_o,
  input  dfia_pkg::res_t               res_o
);

  // A free completes in the beat right after it is taken
  a_free_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i.command == dfia_pkg::CMD_FREE |=> res_valid_o && !busy_o)
    else $error("free did not return its result in one cycle");

  // A retire always occupies the sequencer
  a_retire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && cmd_i.command == dfia_pkg::CMD_RETIRE |=> busy_o && !res_valid_o)
    else $error("retire did not hold busy");

  // Ending a multi-cycle command delivers its result
  a_result_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o)
    else $error("busy dropped without a result");

  // An exhaustion report comes only with the aliased index
  a_report_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.report_exhaustion |->
      res_o.status == dfia_pkg::ST_EXHAUSTED && res_o.index == '0 &&
      res_o.released_count == '0)
    else $error("exhaustion report with inconsistent result");

  // Released indices come only from retire, which allocates nothing
  a_release_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.released_count != '0 |->
      res_o.index == '0 && res_o.status != dfia_pkg::ST_EXHAUSTED)
    else $error("released count together with allocation fields");

endmodule

bind deferred_free_index_allocator dfia_checker u_dfia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .cmd_i       (cmd_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ----- test/deferred_free_index_allocator_test.sv -----
// Self-checking testbench for the deferred-reclaim slot index allocator.
module deferred_free_index_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dfia_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_BEATS = 125;

  typedef enum logic {
    ROW_BEAT,
    ROW_CAPACITY
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    cmd_t             beat;
    logic [CAP_W-1:0] cap_value;
    logic             typed;
    res_t             want;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  cmd_t             cmd_i = '0;
  logic             res_valid_o;
  res_t             res_o;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_data_i = '0;

  // Mirror of the allocator state
  logic [IDX_W-1:0] stack_ix [HEAP_DEPTH];
  int unsigned      stack_fill;
  logic [IDX_W-1:0] pend_ix [DEFER_SLOTS][HEAP_DEPTH];
  int unsigned      pend_len [DEFER_SLOTS];
  int unsigned      slot_now;
  bit               exhaust_seen;

  res_t             outcome_q [$];
  logic [IDX_W-1:0] held_q [$];
  plan_row_t        plan [$];

  int unsigned cycle_count;
  int          mismatches;
  int          n_beats, n_settings, n_exhaust, n_drops, n_reclaimed;
  bit          gaps_on = 1'b1;

  deferred_free_index_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Reload the free stack, clamping the capacity to the heap depth
  function automatic void reload_stack(input logic [CAP_W-1:0] cap);
    int unsigned n;
    n = (cap > HEAP_DEPTH) ? HEAP_DEPTH : cap;
    for (int unsigned i = 0; i < n; i++) stack_ix[i] = IDX_W'(n - 1 - i);
    stack_fill = n;
  endfunction

  // Apply one command to the mirror and return its result
  function automatic res_t predict_outcome(input cmd_t c);
    res_t        r;
    int unsigned n;
    r = '0;
    case (c.command)
      CMD_ALLOC: begin
        if (stack_fill == 0) begin
          r.status = ST_EXHAUSTED;
          r.report_exhaustion = !exhaust_seen;
          exhaust_seen = 1'b1;
        end else begin
          stack_fill--;
          r.index = stack_ix[stack_fill];
        end
      end
      CMD_FREE: begin
        if (!c.no_index) begin
          n = pend_len[slot_now];
          if (n >= HEAP_DEPTH) begin
            r.status = ST_DROPPED;
          end else begin
            pend_ix[slot_now][n] = c.free_index;
            pend_len[slot_now] = n + 1;
          end
        end
      end
      CMD_RETIRE: begin
        slot_now = (slot_now + 1) % DEFER_SLOTS;
        n = pend_len[slot_now];
        // Push in free order, so the last one freed lands on top
        for (int unsigned i = 0; i < n; i++) begin
          if (stack_fill < HEAP_DEPTH) begin
            stack_ix[stack_fill] = pend_ix[slot_now][i];
            stack_fill++;
            r.released_count++;
          end else begin
            r.status = ST_DROPPED;
          end
        end
        pend_len[slot_now] = 0;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic plan_row_t beat_row(input logic [1:0] op, input logic [IDX_W-1:0] fi,
                                         input logic ni);
    plan_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.beat.command = op;
    row.beat.free_index = fi;
    row.beat.no_index = ni;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input logic [1:0] op, input logic [IDX_W-1:0] fi,
                                          input logic ni, input logic [IDX_W-1:0] idx,
                                          input status_e st, input logic rep,
                                          input logic [CNT_W-1:0] rel);
    plan_row_t row;
    row = beat_row(op, fi, ni);
    row.typed = 1'b1;
    row.want.index = idx;
    row.want.status = st;
    row.want.report_exhaustion = rep;
    row.want.released_count = rel;
    return row;
  endfunction

  function automatic plan_row_t cap_row(input logic [CAP_W-1:0] v);
    plan_row_t row;
    row = '0;
    row.kind = ROW_CAPACITY;
    row.cap_value = v;
    return row;
  endfunction

  // Append one row to the directed plan
  function automatic void add_row(input plan_row_t row);
    plan = {plan, row};
  endfunction

  // Mostly short gaps, a few long ones, none while a burst stretch is on
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drop start for a while
  task automatic hold_off(input int unsigned n);
    if (n != 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Drive one command beat and queue its expected result
  task automatic issue_cmd(input cmd_t c, input logic typed, input res_t want,
                           output res_t got);
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    got = predict_outcome(c);
    outcome_q = {outcome_q, (typed ? want : got)};
    n_beats++;
    if (got.status == ST_EXHAUSTED) n_exhaust++;
    if (got.status == ST_DROPPED) n_drops++;
    n_reclaimed += got.released_count;
    if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
  endtask

  // Write the capacity register once the allocator has drained
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reload_stack(v);
    n_settings++;
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no expectation pending: %p", res_o);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (res_o.index !== want.index) begin
          $error("index: expected %0d, got %0d", want.index, res_o.index);
          mismatches++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          mismatches++;
        end
        if (res_o.report_exhaustion !== want.report_exhaustion) begin
          $error("report_exhaustion: expected %0d, got %0d",
                 want.report_exhaustion, res_o.report_exhaustion);
          mismatches++;
        end
        if (res_o.released_count !== want.released_count) begin
          $error("released_count: expected %0d, got %0d",
                 want.released_count, res_o.released_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cmd_t             c;
    res_t             got;
    int unsigned      roll, k;
    logic [CAP_W-1:0] cap;

    reload_stack(CAP_W'(HEAP_DEPTH));
    foreach (pend_len[s]) pend_len[s] = 0;
    slot_now = 0;
    exhaust_seen = 1'b0;

    // Directed sequence: reset stack order, reclaim order, exhaustion, clamping
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_ALLOC, 12'hFFF, 1'b1, 12'd1, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_FREE, 12'hFFF, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_FREE, 12'hFFF, 1'b1, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_UNUSED, 12'hABC, 1'b1, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_RETIRE, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_RETIRE, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_RETIRE, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd1));
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'hFFF, ST_OK, 1'b0, 13'd0));
    add_row(cap_row(13'd1));
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'd0, ST_EXHAUSTED, 1'b1, 13'd0));
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'd0, ST_EXHAUSTED, 1'b0, 13'd0));
    add_row(cap_row(13'd0));
    add_row(typed_row(CMD_FREE, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_FREE, 12'hFFF, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'd0, ST_EXHAUSTED, 1'b0, 13'd0));
    add_row(cap_row(13'h1FFF));
    add_row(typed_row(CMD_RETIRE, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(typed_row(CMD_RETIRE, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    // Stack is full, so both pending indices are dropped
    add_row(typed_row(CMD_RETIRE, 12'h000, 1'b0, 12'd0, ST_DROPPED, 1'b0, 13'd0));
    add_row(typed_row(CMD_ALLOC, 12'h000, 1'b0, 12'd0, ST_OK, 1'b0, 13'd0));
    add_row(beat_row(CMD_FREE, 12'h555, 1'b0));
    add_row(beat_row(CMD_FREE, 12'hAAA, 1'b0));
    add_row(beat_row(CMD_ALLOC, 12'h000, 1'b0));

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAPACITY) begin
        write_capacity(plan[i].cap_value);
      end else begin
        issue_cmd(plan[i].beat, plan[i].typed, plan[i].want, got);
        hold_off(pick_gap());
      end
    end

    // Random phases, each under its own capacity
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       cap = CAP_W'($urandom_range(HEAP_DEPTH, 8191));
        1:       cap = 13'd1;
        2:       cap = CAP_W'($urandom_range(2, 40));
        3:       cap = 13'd0;
        default: cap = CAP_W'($urandom_range(1, 8191));
      endcase
      write_capacity(cap);
      repeat (PHASE_BEATS) begin
        roll = $urandom_range(0, 99);
        c.free_index = IDX_W'($urandom);
        c.no_index = 1'b0;
        if (roll < 40) begin
          c.command = CMD_ALLOC;
        end else if (roll < 75) begin
          c.command = CMD_FREE;
          // Mostly return indices that were handed out
          if (held_q.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, held_q.size() - 1);
            c.free_index = held_q[k];
            held_q.delete(k);
          end
        end else if (roll < 91) begin
          c.command = CMD_RETIRE;
        end else if (roll < 96) begin
          c.command = CMD_FREE;
          c.no_index = 1'b1;
        end else begin
          c.command = CMD_UNUSED;
          c.no_index = 1'($urandom);
        end
        issue_cmd(c, 1'b0, '0, got);
        if (c.command == CMD_ALLOC && got.status == ST_OK) held_q = {held_q, got.index};
        hold_off(pick_gap());
      end
    end

    // Drain and let the block settle
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d commands under %0d capacity settings", n_beats, n_settings);
    $display("Saw %0d exhausted allocations, %0d dropped pushes, %0d indices reclaimed",
             n_exhaust, n_drops, n_reclaimed);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
